// ===== rtl/u2rs_pkg.sv =====
// Shared types, constants and the digit-to-ASCII function for the radix string converter.
// No dependencies; the divider, the converter, the checker and the testbench import this package.
`timescale 1ns / 1ps

package u2rs_pkg;

	localparam int VALUE_WIDTH_DEF = 32;
	localparam int BASE_W = 6;
	localparam int CHAR_W = 8;
	localparam int STEP_BITS = 8;

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd36;

	localparam logic [CHAR_W-1:0] CHAR_NUL = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
	localparam logic [BASE_W-1:0] DEC_DIGITS = 6'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT,
		ST_TERM
	} u2rs_state_t;

	// Status that the divider reports back to the sequencer.
	typedef struct packed {
		logic done;
		logic quo_zero;
	} div_stat_t;

	// Digit value 0..35 to its lower-case ASCII character.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [BASE_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS) begin
			c = CHAR_ZERO + CHAR_W'(d);
		end else begin
			c = CHAR_LOWER_A + CHAR_W'(d - DEC_DIGITS);
		end
		return c;
	endfunction

endpackage

// ===== rtl/u2rs_ram.sv =====
// Generic single-port RAM with one write or read per cycle and a registered read.
// Depends on nothing; the digit store of the converter is one instance.
`timescale 1ns / 1ps

module u2rs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/u2rs_divider.sv =====
// Shared divider: divides the value by the base, eight quotient bits per cycle.
// Depends on u2rs_pkg for the base width, the step size and the status struct.
`timescale 1ns / 1ps

module u2rs_divider
	import u2rs_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [VALUE_WIDTH-1:0] dividend,
	input  logic [BASE_W-1:0]      divisor,
	output logic [VALUE_WIDTH-1:0] quotient,
	output logic [BASE_W-1:0]      remainder,
	output div_stat_t              stat
);

	localparam int CHUNKS = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
	localparam int PAD_W = CHUNKS * STEP_BITS;
	localparam int CNT_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;

	logic [PAD_W-1:0]     wrk_q;
	logic [BASE_W-1:0]    rmd_q;
	logic [BASE_W-1:0]    dvs_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 run_q;
	logic                 done_q;

	logic [PAD_W-1:0]     src;
	logic [BASE_W-1:0]    dvs;
	logic [BASE_W-1:0]    rmd_d;
	logic [STEP_BITS-1:0] qbits;
	logic                 active;
	logic                 last_chunk;

	assign active = start | run_q;
	assign last_chunk = start ? (CHUNKS == 1) : (cnt_q == CNT_W'(CHUNKS - 1));

	// The working word shifts dividend bits out at the top and quotient bits in at
	// the bottom; after the last chunk it holds the whole quotient.
	always_comb begin
		logic [BASE_W-1:0] r;
		logic [BASE_W:0]   t;
		src = start ? PAD_W'(dividend) : wrk_q;
		dvs = start ? divisor : dvs_q;
		r = start ? '0 : rmd_q;
		qbits = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			t = {r, src[PAD_W-1-i]};
			if (t >= {1'b0, dvs}) begin
				t = t - {1'b0, dvs};
				qbits[STEP_BITS-1-i] = 1'b1;
			end
			r = t[BASE_W-1:0];
		end
		rmd_d = r;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= active & last_chunk;
			if (active) begin
				run_q <= ~last_chunk;
				cnt_q <= start ? CNT_W'(1) : cnt_q + CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (active) begin
			wrk_q <= (src << STEP_BITS) | PAD_W'(qbits);
			rmd_q <= rmd_d;
		end
		if (start) begin
			dvs_q <= divisor;
		end
	end

	assign quotient = wrk_q[VALUE_WIDTH-1:0];
	assign remainder = rmd_q;
	assign stat.done = done_q;
	assign stat.quo_zero = (wrk_q == '0);

endmodule

// ===== rtl/unsigned_to_radix_string.sv =====
// Throughput: one item per busy period; a new item is accepted only while busy is low.
// The shared divider retires eight quotient bits a cycle. An invalid base skips the
// divider and goes straight to ST_TERM for the terminator word.
// Reset: arst_n clears the sequencer and output strobe asynchronously; results cannot be
// stalled, each character word is valid for exactly one cycle while strobe is high.
`timescale 1ns / 1ps

module unsigned_to_radix_string
	import u2rs_pkg::*;
#(
	parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  logic [VALUE_WIDTH-1:0] value,
	input  logic [BASE_W-1:0]      base,
	output logic                   strobe,
	output logic [CHAR_W-1:0]      char_code,
	output logic                   last,
	output logic                   base_error
);

	// The digit store holds up to one digit per value bit (base 2).
	localparam int DIG_AW = (VALUE_WIDTH > 1) ? $clog2(VALUE_WIDTH) : 1;
	localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

	u2rs_state_t state_q, state_d;

	logic [CNT_W-1:0]       cnt_q;
	logic                   bad_base_q;
	logic [BASE_W-1:0]      base_q;

	logic                   rd_s1;
	logic                   term_s1;
	logic                   err_s1;

	logic                   strobe_q;
	logic [CHAR_W-1:0]      char_q;
	logic                   last_q;
	logic                   base_error_q;

	logic                   base_ok;
	logic                   accept;
	logic                   div_start;
	logic                   div_from_input;
	logic                   dig_we;
	logic                   dig_re;
	logic                   term_issue;

	logic [VALUE_WIDTH-1:0] div_dividend;
	logic [BASE_W-1:0]      div_divisor;
	logic [VALUE_WIDTH-1:0] quotient;
	logic [BASE_W-1:0]      remainder;
	div_stat_t              dstat;

	logic [CNT_W-1:0]       cnt_dec;
	logic [DIG_AW-1:0]      dig_addr;
	logic [BASE_W-1:0]      dig_rdata;

	assign base_ok = (base >= BASE_MIN) && (base <= BASE_MAX);
	assign accept = start && (state_q == ST_IDLE);
	assign busy = (state_q != ST_IDLE);

	// Next-state logic. Digits come out least significant first during ST_DIV and are
	// read back in reverse order during ST_EMIT; ST_TERM sends the terminator word.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					state_d = base_ok ? ST_DIV : ST_TERM;
				end
			end
			ST_DIV: begin
				if (dstat.done && dstat.quo_zero) begin
					state_d = ST_EMIT;
				end
			end
			ST_EMIT: begin
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_TERM;
				end
			end
			ST_TERM: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs. A new division starts either from the input value or, when the
	// previous one finished with a nonzero quotient, from that quotient in the same cycle.
	always_comb begin
		div_start = 1'b0;
		div_from_input = 1'b0;
		dig_we = 1'b0;
		dig_re = 1'b0;
		term_issue = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				div_from_input = 1'b1;
				div_start = start && base_ok;
			end
			ST_DIV: begin
				dig_we = dstat.done;
				div_start = dstat.done && !dstat.quo_zero;
			end
			ST_EMIT: begin
				dig_re = 1'b1;
			end
			ST_TERM: begin
				term_issue = 1'b1;
			end
			default: begin
				term_issue = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			bad_base_q <= 1'b0;
			base_q <= '0;
			rd_s1 <= 1'b0;
			term_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				cnt_q <= '0;
				bad_base_q <= ~base_ok;
				base_q <= base;
			end else if (dig_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (dig_re) begin
				cnt_q <= cnt_dec;
			end
			rd_s1 <= dig_re;
			term_s1 <= term_issue;
			strobe_q <= rd_s1 | term_s1;
		end
	end

	// Output word registers; strobe alone qualifies them.
	always_ff @(posedge clk) begin
		err_s1 <= bad_base_q;
		char_q <= term_s1 ? CHAR_NUL : digit_char(dig_rdata);
		last_q <= term_s1;
		base_error_q <= term_s1 & err_s1;
	end

	// The base port may change once the word is accepted, so every later division of
	// the same word uses the base captured at the accept.
	assign div_dividend = div_from_input ? value : quotient;
	assign div_divisor = div_from_input ? base : base_q;

	u2rs_divider #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (quotient),
		.remainder(remainder),
		.stat     (dstat)
	);

	// Writes go to the next free slot; reads walk back from the most significant digit.
	assign cnt_dec = cnt_q - CNT_W'(1);
	assign dig_addr = dig_we ? cnt_q[DIG_AW-1:0] : cnt_dec[DIG_AW-1:0];

	u2rs_ram #(
		.WIDTH(BASE_W),
		.DEPTH(VALUE_WIDTH)
	) u_dig_ram (
		.clk  (clk),
		.we   (dig_we),
		.re   (dig_re),
		.addr (dig_addr),
		.wdata(remainder),
		.rdata(dig_rdata)
	);

	assign strobe = strobe_q;
	assign char_code = char_q;
	assign last = last_q;
	assign base_error = base_error_q;

endmodule

// ===== rtl/u2rs_checker.sv =====
// Port-level checks on the radix string converter, attached by the bind at the end.
// Depends on u2rs_pkg and on the port names of unsigned_to_radix_string.
`timescale 1ns / 1ps

module u2rs_checker
	import u2rs_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic [BASE_W-1:0] base,
	input logic              strobe,
	input logic [CHAR_W-1:0] char_code,
	input logic              last,
	input logic              base_error
);

	// An error word is always the bare terminator.
	a_err_is_term: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && base_error |-> last && (char_code == CHAR_NUL))
		else $error("error word is not a terminator");

	// Every word before the terminator is a lower-case digit character.
	a_digit_chars: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |->
			((char_code >= 8'h30) && (char_code <= 8'h39)) ||
			((char_code >= 8'h61) && (char_code <= 8'h7a)))
		else $error("digit word is not a digit character");

	// An invalid base gives the error terminator after the accept, by way of ST_TERM, term_s1 and the output registers.
	a_bad_base: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && ((base < BASE_MIN) || (base > BASE_MAX)) |->
			##3 (strobe && last && base_error))
		else $error("invalid base did not produce the error terminator");

	// The next string never starts right after a terminator.
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |=> !strobe)
		else $error("word strobed directly after a terminator");

	// An accepted item keeps the block busy in the following cycle.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block not busy after accepting an item");

endmodule

bind unsigned_to_radix_string u2rs_checker u_u2rs_checker (.*);

// ===== tb/tb_unsigned_to_radix_string.sv =====
// Self-checking testbench for unsigned_to_radix_string: directed and random words are
// converted by an in-bench predictor and every character strobe is checked against it.
// Depends on u2rs_pkg and the unsigned_to_radix_string RTL; nothing else.
`timescale 1ns / 1ps

module tb_unsigned_to_radix_string;
	import u2rs_pkg::*;

	localparam int VW = VALUE_WIDTH_DEF;
	// The slowest word is base 2 with all 32 digits; a quiet stretch far longer than that word
	// needs before its first strobe is a hang.
	localparam int QUIET_LIMIT = 2000;
	// Cycles to wait after the last character, so a stray extra strobe is still caught.
	localparam int TAIL_CYCLES = 200;
	localparam int GAP_MAX = 20;

	// One character word as the block presents it on its result ports.
	typedef struct {
		logic [CHAR_W-1:0] ch;
		logic              lst;
		logic              err;
	} char_word_t;

	logic              clk;
	logic              arst_n;
	logic              start;
	logic              busy;
	logic [VW-1:0]     value;
	logic [BASE_W-1:0] base;
	logic              strobe;
	logic [CHAR_W-1:0] char_code;
	logic              last;
	logic              base_error;

	// Characters that the predictor says are still to come, oldest first.
	char_word_t pending_chars[$];

	int  mismatch_count;
	int  words_sent;
	int  bad_base_sent;
	int  chars_checked;
	int  quiet_cycles;
	// When set, the sender puts no idle cycles between words.
	bit  no_idle;

	unsigned_to_radix_string u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.value      (value),
		.base       (base),
		.strobe     (strobe),
		.char_code  (char_code),
		.last       (last),
		.base_error (base_error)
	);

	// 4 ns clock, 2 ns high and 2 ns low.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Print one line for a mismatch and count it. The run carries on.
	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t ns: %s", $time, msg);
		mismatch_count++;
	endtask

	// Predict the characters of one word. The block keeps no state between words, so the
	// expected string depends only on the value and the base. Digits are found least
	// significant first and pushed to the front, which leaves them most significant first.
	function automatic void predict_radix_string(input logic [VW-1:0] v, input logic [BASE_W-1:0] b);
		logic [VW-1:0]     rem_val;
		logic [VW-1:0]     radix;
		logic [VW-1:0]     d;
		logic [VW-1:0]     digs[$];
		char_word_t        cw;
		rem_val = v;
		radix = VW'(b);
		if (b < BASE_MIN || b > BASE_MAX) begin
			// An out-of-range base gives the terminator alone, flagged as an error.
			cw.ch = '0;
			cw.lst = 1'b1;
			cw.err = 1'b1;
			pending_chars.push_back(cw);
			return;
		end
		// A do-while loop makes a zero value still give the single digit zero.
		do begin
			digs.push_front(rem_val % radix);
			rem_val = rem_val / radix;
		end while (rem_val != 0);
		foreach (digs[i]) begin
			d = digs[i];
			cw.ch = (d < 10) ? CHAR_W'(8'h30 + d) : CHAR_W'(8'h61 + (d - 10));
			cw.lst = 1'b0;
			cw.err = 1'b0;
			pending_chars.push_back(cw);
		end
		cw.ch = '0;
		cw.lst = 1'b1;
		cw.err = 1'b0;
		pending_chars.push_back(cw);
	endfunction

	// Send one word. An optional run of idle cycles comes first, then start is raised and
	// held until an edge where busy was low, which is the edge that accepts the word. Start
	// is left high on return, so a following word with no gap keeps it high without a dip.
	task automatic send_word(input logic [VW-1:0] v, input logic [BASE_W-1:0] b);
		int gap;
		gap = 0;
		if (!no_idle) begin
			while (gap < GAP_MAX && $urandom_range(99) < 34) begin
				gap++;
			end
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		value <= v;
		base <= b;
		do begin
			@(posedge clk);
		end while (busy);
		predict_radix_string(v, b);
		words_sent++;
		if (b < BASE_MIN || b > BASE_MAX) begin
			bad_base_sent++;
		end
	endtask

	// Lower start and wait until every predicted character has come out.
	task automatic drain_results();
		start <= 1'b0;
		do begin
			@(posedge clk);
		end while (pending_chars.size() != 0);
	endtask

	// Pick a value that lands on digit-count boundaries as well as plain random ones.
	function automatic logic [VW-1:0] pick_value(input logic [BASE_W-1:0] b);
		logic [63:0] pw;
		int          k;
		pw = 64'd1;
		k = $urandom_range(VW);
		case ($urandom_range(5))
			0: begin
				return $urandom;
			end
			1: begin
				return VW'($urandom_range(40));
			end
			2: begin
				// A power of the base or one less: the point where a digit is added.
				if (b >= BASE_MIN && b <= BASE_MAX) begin
					repeat (k) begin
						if (pw * b <= 64'hFFFF_FFFF) begin
							pw = pw * b;
						end
					end
				end
				return VW'(pw - 64'($urandom_range(1)));
			end
			3: begin
				return VW'(64'd1 << $urandom_range(VW - 1));
			end
			4: begin
				return {VW{1'b1}} >> $urandom_range(VW - 1);
			end
			default: begin
				return $urandom >> $urandom_range(VW - 1);
			end
		endcase
	endfunction

	// Mostly valid bases; the rest spread over 0, 1 and 37 to 63.
	function automatic logic [BASE_W-1:0] pick_base();
		if ($urandom_range(99) < 88) begin
			return BASE_W'($urandom_range(BASE_MAX, BASE_MIN));
		end
		if ($urandom_range(2) == 0) begin
			return BASE_W'($urandom_range(1));
		end
		return BASE_W'($urandom_range(63, 37));
	endfunction

	// Every base outside 2 to 36 must give the flagged terminator alone, whatever the value.
	task automatic test_invalid_bases();
		send_word(32'hFFFF_FFFF, 6'd0);
		send_word(32'd0, 6'd1);
		send_word(32'd12345, 6'd37);
		send_word(32'hFFFF_FFFF, 6'd63);
	endtask

	// Zero converts to the single digit zero in any base.
	task automatic test_zero_value();
		send_word(32'd0, BASE_MIN);
		send_word(32'd0, 6'd10);
		send_word(32'd0, BASE_MAX);
	endtask

	// Largest and smallest values at the edge bases, and one-digit to two-digit steps.
	task automatic test_extremes();
		send_word(32'hFFFF_FFFF, BASE_MIN);
		send_word(32'hFFFF_FFFF, BASE_MAX);
		send_word(32'hFFFF_FFFF, 6'd16);
		send_word(32'hFFFF_FFFF, 6'd10);
		send_word(32'h8000_0000, BASE_MIN);
		send_word(32'd1, BASE_MIN);
		send_word(32'd35, BASE_MAX);
		send_word(32'd36, BASE_MAX);
		send_word(32'h5555_5555, BASE_MIN);
		send_word(32'hAAAA_AAAA, 6'd3);
		send_word(32'd9, 6'd10);
		send_word(32'd10, 6'd10);
	endtask

	// Hold the sender off until the block has emptied, then send again from a quiet start.
	task automatic test_drained_restart();
		drain_results();
		send_word(32'd123456789, 6'd10);
		send_word(32'hDEAD_BEEF, 6'd16);
	endtask

	// Back-to-back words with start never dropped between them.
	task automatic test_back_to_back(input int n_words);
		no_idle = 1'b1;
		repeat (n_words) begin
			send_word(pick_value(BASE_W'(10)), pick_base());
		end
		no_idle = 1'b0;
	endtask

	// Random words with random spacing.
	task automatic test_random_words(input int n_words);
		logic [BASE_W-1:0] b;
		repeat (n_words) begin
			b = pick_base();
			send_word(pick_value(b), b);
		end
	endtask

	// Each strobe is one character word. It is compared field by field with the oldest
	// prediction. Outputs are read at the rising edge, before the block updates them.
	always @(posedge clk) begin : check_chars
		char_word_t want;
		if (arst_n && strobe) begin
			chars_checked++;
			if (pending_chars.size() == 0) begin
				report_mismatch($sformatf("character 0x%02h with nothing expected", char_code));
			end else begin
				want = pending_chars.pop_front();
				if (char_code !== want.ch) begin
					report_mismatch($sformatf("char_code 0x%02h, expected 0x%02h",
						char_code, want.ch));
				end
				if (last !== want.lst) begin
					report_mismatch($sformatf("last %b, expected %b", last, want.lst));
				end
				if (base_error !== want.err) begin
					report_mismatch($sformatf("base_error %b, expected %b",
						base_error, want.err));
				end
			end
		end
	end

	// Watchdog: count cycles in which neither a word nor a character is accepted.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Timeout after %0d quiet cycles", quiet_cycles);
				$display("end of test: mismatches");
				$finish;
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		value = '0;
		base = '0;
		no_idle = 1'b0;
		mismatch_count = 0;
		words_sent = 0;
		bad_base_sent = 0;
		chars_checked = 0;
		quiet_cycles = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_invalid_bases();
		test_zero_value();
		test_extremes();
		test_drained_restart();
		test_back_to_back(40);
		test_random_words(300);

		// Let the last word finish, then watch a while longer for stray strobes.
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (pending_chars.size() != 0) begin
			report_mismatch($sformatf("%0d characters never arrived", pending_chars.size()));
		end

		$display("Sent %0d words (%0d with an out-of-range base) and checked %0d characters,",
			words_sent, bad_base_sent, chars_checked);
		$display("covering bases 0 to 63, zero and full-scale values, gaps and back-to-back.");
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
